>>> sv/fiv_pkg.sv
// Package: constants and types for the firmware image validator.
package fiv_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = $clog2(MAX_SECTIONS);
    localparam int CNT_W        = IDX_W + 1;
    localparam logic [31:0] HEADER_BYTES = 32'd32;
    localparam logic [31:0] ENTRY_BYTES  = 32'd12;

    localparam logic [31:0] TARGET_CODE_REQ = 32'h0000_5043;
    localparam logic [31:0] CRC_POLY        = 32'hedb8_8320;
    localparam logic [32:0] WIN_LOW         = 33'h0_6000;
    localparam logic [32:0] WIN_HIGH        = 33'h1_5ff8;
    localparam logic [32:0] SIG_LOW         = 33'h0_ff80;
    localparam logic [32:0] SIG_END         = 33'h0_ff90;

    localparam logic [1:0] CMD_HEADER = 2'd0;
    localparam logic [1:0] CMD_ENTRY  = 2'd1;
    localparam logic [1:0] CMD_DATA   = 2'd2;

    localparam logic [1:0] CFG_STAGED_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAGIC       = 2'd1;
    localparam logic [1:0] CFG_VERSION     = 2'd2;

    localparam logic [2:0] ST_BUSY  = 3'd0;
    localparam logic [2:0] ST_VALID = 3'd1;
    localparam logic [2:0] ST_ARG   = 3'd2;
    localparam logic [2:0] ST_SIZE  = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WALK_CHK,
        S_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TABLE,
        PH_DATA,
        PH_DONE
    } phase_t;

    // One byte of reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

>>> sv/firmware_image_validator.sv
// Firmware image validator: header, section table and payload CRC checks.
// A header or data result is offered in the cycle after its transfer; a section entry that
// passes the pre-checks first waits for a table walk over the earlier entries (S_WALK, S_WALK_CHK).
// The input waits while a result is pending, so a new item is not taken before the last
// result has been accepted; result stalls hold the input further.
// Reset (rst_n, async, active low) returns to expecting a header, verdict
// in progress; the section table memory is not cleared.
module firmware_image_validator
    import fiv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: magic, format version, header length, total length, target code,
    // sec count, image crc, sec addr, sec len, sec crc, data byte (lowest first)
    input  logic [279:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // status [2:0], done_res [3]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    // Input field unpacking
    logic [31:0] in_magic, in_total, in_target, in_icrc, in_addr, in_len, in_scrc;
    logic [15:0] in_ver, in_hlen, in_count;
    logic [7:0]  in_byte;
    assign in_magic  = s_axis_tdata[31:0];
    assign in_ver    = s_axis_tdata[47:32];
    assign in_hlen   = s_axis_tdata[63:48];
    assign in_total  = s_axis_tdata[95:64];
    assign in_target = s_axis_tdata[127:96];
    assign in_count  = s_axis_tdata[143:128];
    assign in_icrc   = s_axis_tdata[175:144];
    assign in_addr   = s_axis_tdata[207:176];
    assign in_len    = s_axis_tdata[239:208];
    assign in_scrc   = s_axis_tdata[271:240];
    assign in_byte   = s_axis_tdata[279:272];

    // Configuration registers
    logic [31:0] staged_size_reg, magic_reg;
    logic [15:0] version_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_size_reg <= '0;
            magic_reg       <= '0;
            version_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STAGED_SIZE: staged_size_reg <= cfg_data;
                CFG_MAGIC:       magic_reg       <= cfg_data;
                CFG_VERSION:     version_reg     <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Section table memory: {crc, length, start}, one read and one write port
    logic [65:0] tbl_mem [MAX_SECTIONS];
    logic [65:0] tbl_rd;
    logic [IDX_W-1:0] rd_addr;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [65:0] wr_data;
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tbl_mem[wr_addr] <= wr_data;
        tbl_rd <= tbl_mem[rd_addr];
    end

    // State
    fsm_t        state_reg, state_next;
    phase_t      phase_reg;
    logic [2:0]  verdict_reg;
    logic [CNT_W-1:0] declared_reg, seen_reg, walk_reg;
    logic [31:0] offset_reg, sec_crc_reg, pay_crc_reg, exp_crc_reg;
    logic [16:0] pos_reg;
    logic [31:0] e_addr_reg, e_len_reg, e_crc_reg;
    logic        data_pend_reg;

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;

    // Data byte taken this cycle
    logic data_take;
    assign data_take = s_fire && verdict_reg == ST_BUSY && phase_reg == PH_DATA &&
                       s_axis_tuser == CMD_DATA;

    // Next state
    logic entry_start, walk_hit;
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (entry_start) state_next = S_WALK;
                        else if (s_fire) state_next = S_OUT;
            S_WALK:     state_next = (walk_reg == seen_reg) ? S_OUT : S_WALK_CHK;
            S_WALK_CHK: state_next = walk_hit ? S_OUT : S_WALK;
            S_OUT:      if (m_axis_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Entry pre-checks computed at acceptance
    logic [32:0] e_end;
    logic win_ok, entry_bad;
    assign e_end = {1'b0, in_addr} + {1'b0, in_len};
    always_comb
    begin
        win_ok = !(in_len == 32'd0 || in_addr[0] || in_len[0] || e_end[32]);
        if ({1'b0, in_addr} < SIG_END && e_end > SIG_LOW)
            win_ok = 1'b0;
        if ({1'b0, in_addr} < WIN_LOW || e_end > WIN_HIGH)
            win_ok = 1'b0;
        entry_bad = (seen_reg >= CNT_W'(MAX_SECTIONS)) || !win_ok ||
                    ({1'b0, offset_reg} + {1'b0, in_len} > {1'b0, staged_size_reg});
    end
    assign entry_start = s_fire && verdict_reg == ST_BUSY && phase_reg == PH_TABLE &&
                         s_axis_tuser == CMD_ENTRY && !entry_bad;

    // Overlap test against the entry read from memory
    logic [31:0] a0, a1;
    assign a0 = tbl_rd[16:0] == 17'd0 ? 32'd0 : {15'd0, tbl_rd[16:0]};
    assign a1 = a0 + {15'd0, tbl_rd[33:17]};
    assign walk_hit = (e_addr_reg < a1) && (a0 < e_addr_reg + e_len_reg);

    // Memory address: seen_reg while idle (current section in the data phase), else walk index
    always_comb
    begin
        rd_addr = walk_reg[IDX_W-1:0];
        if (state_reg == S_IDLE)
            rd_addr = seen_reg[IDX_W-1:0];
        wr_en   = (state_reg == S_WALK) && (walk_reg == seen_reg);
        wr_addr = seen_reg[IDX_W-1:0];
        wr_data = {e_crc_reg, e_len_reg[16:0], e_addr_reg[16:0]};
    end

    // Datapath
    logic [31:0] need;
    logic [31:0] c_sec, c_pay;
    logic [16:0] pos_inc;
    assign need    = HEADER_BYTES + ENTRY_BYTES * {16'd0, in_count};
    assign c_sec   = crc_byte(sec_crc_reg, in_byte);
    assign c_pay   = crc_byte(pay_crc_reg, in_byte);
    assign pos_inc = pos_reg + 17'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            verdict_reg   <= ST_BUSY;
            declared_reg  <= '0;
            seen_reg      <= '0;
            walk_reg      <= '0;
            offset_reg    <= '0;
            pos_reg       <= '0;
            sec_crc_reg   <= '1;
            pay_crc_reg   <= '1;
            exp_crc_reg   <= '0;
            data_pend_reg <= 1'b0;
            e_addr_reg    <= '0;
            e_len_reg     <= '0;
            e_crc_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            data_pend_reg <= data_take;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_fire && verdict_reg == ST_BUSY)
                    begin
                        if (phase_reg == PH_HEADER && s_axis_tuser == CMD_HEADER)
                        begin
                            if (staged_size_reg < HEADER_BYTES || in_magic != magic_reg ||
                                in_ver != version_reg || {16'd0, in_hlen} != HEADER_BYTES ||
                                in_total != staged_size_reg || in_target != TARGET_CODE_REQ ||
                                in_count == 16'd0 || in_count > 16'(MAX_SECTIONS))
                                verdict_reg <= ST_ARG;
                            else if (need > staged_size_reg)
                                verdict_reg <= ST_SIZE;
                            else
                            begin
                                declared_reg <= CNT_W'(in_count);
                                seen_reg     <= '0;
                                offset_reg   <= need;
                                exp_crc_reg  <= in_icrc;
                                phase_reg    <= PH_TABLE;
                            end
                        end
                        else if (phase_reg == PH_TABLE && s_axis_tuser == CMD_ENTRY)
                        begin
                            if (entry_bad)
                                verdict_reg <= ST_ARG;
                            else
                            begin
                                e_addr_reg <= in_addr;
                                e_len_reg  <= in_len;
                                e_crc_reg  <= in_scrc;
                                walk_reg   <= '0;
                            end
                        end
                        else if (phase_reg == PH_DATA && s_axis_tuser == CMD_DATA)
                        begin
                            // table row of current section is in tbl_rd next cycle
                            sec_crc_reg <= c_sec;
                            pay_crc_reg <= c_pay;
                            pos_reg     <= pos_inc;
                        end
                        else
                            verdict_reg <= ST_ARG;
                    end
                end
                S_WALK:
                begin
                    if (walk_reg == seen_reg)
                    begin
                        offset_reg <= offset_reg + e_len_reg;
                        if (seen_reg + CNT_W'(1) != declared_reg)
                            seen_reg <= seen_reg + CNT_W'(1);
                        else if (offset_reg + e_len_reg != staged_size_reg)
                        begin
                            seen_reg    <= seen_reg + CNT_W'(1);
                            verdict_reg <= ST_SIZE;
                        end
                        else
                        begin
                            seen_reg    <= '0;
                            pos_reg     <= '0;
                            sec_crc_reg <= '1;
                            pay_crc_reg <= '1;
                            phase_reg   <= PH_DATA;
                        end
                    end
                end
                S_WALK_CHK:
                begin
                    if (walk_hit)
                        verdict_reg <= ST_ARG;
                    walk_reg <= walk_reg + CNT_W'(1);
                end
                S_OUT:
                begin
                    if (data_pend_reg && pos_reg == tbl_rd[33:17])
                    begin
                        if (~sec_crc_reg != tbl_rd[65:34])
                            verdict_reg <= ST_CRC;
                        else
                        begin
                            seen_reg    <= seen_reg + CNT_W'(1);
                            pos_reg     <= '0;
                            sec_crc_reg <= '1;
                            if (seen_reg + CNT_W'(1) == declared_reg)
                            begin
                                phase_reg   <= PH_DONE;
                                verdict_reg <= (~pay_crc_reg == exp_crc_reg) ? ST_VALID : ST_CRC;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result in S_OUT includes the data-phase update, computed combinationally before it is registered
    logic [2:0] status_now;
    always_comb
    begin
        status_now = verdict_reg;
        if (data_pend_reg && verdict_reg == ST_BUSY && pos_reg == tbl_rd[33:17])
        begin
            if (~sec_crc_reg != tbl_rd[65:34])
                status_now = ST_CRC;
            else if (seen_reg + CNT_W'(1) == declared_reg)
                status_now = (~pay_crc_reg == exp_crc_reg) ? ST_VALID : ST_CRC;
        end
    end
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {4'd0, status_now != ST_BUSY, status_now};

endmodule

>>> sv/fiv_checker.sv
// Port-level checker for the firmware image validator, bound to the top level.
module fiv_checker
    import fiv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // First final verdict seen on the result side
    logic       final_seen_reg;
    logic [3:0] final_val_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_seen_reg <= 1'b0;
            final_val_reg  <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[3] && !final_seen_reg)
        begin
            final_seen_reg <= 1'b1;
            final_val_reg  <= m_axis_tdata[3:0];
        end
    end

    // done flag matches a nonzero status
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[2:0] != ST_BUSY)))
        else $error("done flag disagrees with status");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no new input while a result waits
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // a final verdict sticks
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && final_seen_reg |-> m_axis_tdata[3:0] == final_val_reg)
        else $error("final verdict changed");

endmodule

bind firmware_image_validator fiv_checker u_fiv_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> sim/tb_firmware_image_validator.sv
`timescale 1ns / 100ps
// Testbench for the firmware image validator: streams one staged image, checks each status.
module tb_firmware_image_validator;
    import fiv_pkg::*;

    // One input item, fields as in the stream layout
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] magic;
        logic [15:0] fmt_ver;
        logic [15:0] hdr_len;
        logic [31:0] tot_len;
        logic [31:0] target;
        logic [15:0] sec_count;
        logic [31:0] img_crc;
        logic [31:0] sec_addr;
        logic [31:0] sec_len;
        logic [31:0] sec_crc;
        logic [7:0]  dbyte;
    } fw_item_t;

    // Directed stimulus row
    typedef struct {
        fw_item_t   item;
        bit         typed;
        logic [2:0] status;
    } stim_row_t;

    localparam logic [1:0] CMD_BAD   = 2'd3;
    localparam int         NUM_SECS  = 16;
    localparam int         NUM_FIXED = 4;
    localparam int         TIMEOUT   = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [279:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    firmware_image_validator uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [31:0] cfg_size, cfg_magic;
    logic [15:0] cfg_ver;
    phase_t      ph;
    logic [15:0] decl_secs, sec_idx;
    logic [31:0] sec_start [MAX_SECTIONS];
    logic [31:0] sec_length [MAX_SECTIONS];
    logic [31:0] sec_crc_tab [MAX_SECTIONS];
    logic [31:0] data_offset;
    logic [16:0] byte_pos;
    logic [31:0] sec_crc_acc, img_crc_acc, img_crc_want;
    logic [2:0]  verdict;

    logic [2:0]  status_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side stalls
    always @(posedge clk)
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 14);

    // Status checker
    always @(posedge clk)
    begin
        logic [2:0] want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (status_q.size() == 0)
            begin
                $error("unexpected status transfer %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = status_q.pop_front();
                if (m_axis_tdata[2:0] !== want)
                begin
                    $error("status: expected %0d actual %0d", want, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[3] !== (want != ST_BUSY))
                begin
                    $error("done_res: expected %0d actual %0d", want != ST_BUSY,
                           m_axis_tdata[3]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ 32'hedb8_8320) : (r >> 1);
        return r;
    endfunction

    function automatic fw_item_t rand_item(logic [1:0] cmd);
        fw_item_t it;
        it.cmd = cmd;
        it.magic = $urandom; it.fmt_ver = 16'($urandom); it.hdr_len = 16'($urandom);
        it.tot_len = $urandom; it.target = $urandom; it.sec_count = 16'($urandom);
        it.img_crc = $urandom; it.sec_addr = $urandom; it.sec_len = $urandom;
        it.sec_crc = $urandom; it.dbyte = 8'($urandom);
        return it;
    endfunction

    // Header check
    function automatic void take_header(fw_item_t it);
        logic [32:0] need;
        if (cfg_size < HEADER_BYTES || it.magic != cfg_magic || it.fmt_ver != cfg_ver ||
            {16'd0, it.hdr_len} != HEADER_BYTES || it.tot_len != cfg_size ||
            it.target != TARGET_CODE_REQ || it.sec_count == 0 ||
            it.sec_count > MAX_SECTIONS)
        begin
            verdict = ST_ARG;
            return;
        end
        need = 33'd32 + 33'd12 * {17'd0, it.sec_count};
        if (need > {1'b0, cfg_size})
        begin
            verdict = ST_SIZE;
            return;
        end
        decl_secs = it.sec_count;
        sec_idx = 0;
        data_offset = need[31:0];
        img_crc_want = it.img_crc;
        ph = PH_TABLE;
    endfunction

    // Section entry: window, alignment, overlap and size
    function automatic void take_entry(fw_item_t it);
        logic [32:0] stop;
        logic [31:0] a1;
        bit          ok;
        stop = {1'b0, it.sec_addr} + {1'b0, it.sec_len};
        ok = !(it.sec_len == 0 || it.sec_addr[0] || it.sec_len[0] || stop[32]);
        if (ok && {1'b0, it.sec_addr} < SIG_END && stop > SIG_LOW)
            ok = 0;
        if (ok && !({1'b0, it.sec_addr} >= WIN_LOW && stop <= WIN_HIGH))
            ok = 0;
        if (sec_idx >= MAX_SECTIONS || !ok ||
            {1'b0, data_offset} + {1'b0, it.sec_len} > {1'b0, cfg_size})
        begin
            verdict = ST_ARG;
            return;
        end
        for (int j = 0; j < sec_idx; j++)
        begin
            a1 = sec_start[j] + sec_length[j];
            if (it.sec_addr < a1 && sec_start[j] < it.sec_addr + it.sec_len)
            begin
                verdict = ST_ARG;
                return;
            end
        end
        sec_start[sec_idx] = it.sec_addr;
        sec_length[sec_idx] = it.sec_len;
        sec_crc_tab[sec_idx] = it.sec_crc;
        data_offset += it.sec_len;
        sec_idx++;
        if (sec_idx == decl_secs)
        begin
            if (data_offset != cfg_size)
            begin
                verdict = ST_SIZE;
                return;
            end
            sec_idx = 0;
            byte_pos = 0;
            sec_crc_acc = '1;
            img_crc_acc = '1;
            ph = PH_DATA;
        end
    endfunction

    // Payload byte: per-section and whole-image CRC
    function automatic void take_byte(fw_item_t it);
        if (sec_idx >= MAX_SECTIONS)
        begin
            verdict = ST_ARG;
            return;
        end
        sec_crc_acc = crc_step(sec_crc_acc, it.dbyte);
        img_crc_acc = crc_step(img_crc_acc, it.dbyte);
        byte_pos = byte_pos + 17'd1;
        if ({15'd0, byte_pos} != sec_length[sec_idx])
            return;
        if (~sec_crc_acc != sec_crc_tab[sec_idx])
        begin
            verdict = ST_CRC;
            return;
        end
        sec_idx++;
        byte_pos = 0;
        sec_crc_acc = '1;
        if (sec_idx == decl_secs)
        begin
            ph = PH_DONE;
            verdict = (~img_crc_acc == img_crc_want) ? ST_VALID : ST_CRC;
        end
    endfunction

    function automatic logic [2:0] predict_status(fw_item_t it);
        if (verdict == ST_BUSY)
        begin
            if (ph == PH_HEADER && it.cmd == CMD_HEADER)
                take_header(it);
            else if (ph == PH_TABLE && it.cmd == CMD_ENTRY)
                take_entry(it);
            else if (ph == PH_DATA && it.cmd == CMD_DATA)
                take_byte(it);
            else
                verdict = ST_ARG;
        end
        return verdict;
    endfunction

    // Send one item; hold tvalid across back-to-back transfers
    task automatic send_item(fw_item_t it, bit typed = 0, logic [2:0] typed_status = '0);
        logic [2:0] st;
        while (!quiet && $urandom_range(0, 99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {it.dbyte, it.sec_crc, it.sec_len, it.sec_addr, it.img_crc,
                         it.sec_count, it.target, it.tot_len, it.hdr_len, it.fmt_ver,
                         it.magic};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        st = predict_status(it);
        if (typed && st != typed_status)
        begin
            $error("status: directed row expected %0d, predicted %0d", typed_status, st);
            errors++;
        end
        status_q.push_back(typed ? typed_status : st);
    endtask

    // Caller drops cfg_valid after the last write of a burst
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_STAGED_SIZE)
            cfg_size = val;
        else if (idx == CFG_MAGIC)
            cfg_magic = val;
        else if (idx == CFG_VERSION)
            cfg_ver = val[15:0];
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        stim_row_t   rows [NUM_FIXED + 1];
        logic [31:0] addrs [NUM_SECS];
        logic [31:0] lens [NUM_SECS];
        logic [31:0] crcs [NUM_SECS];
        logic [7:0]  payload [$];
        logic [31:0] cursor, total, icrc, c;
        int          pos, mode, hit;
        fw_item_t    it;

        // Predictor reset state
        cfg_size = 0; cfg_magic = 0; cfg_ver = 0;
        ph = PH_HEADER; decl_secs = 0; sec_idx = 0; data_offset = 0; byte_pos = 0;
        sec_crc_acc = '1; img_crc_acc = '1; img_crc_want = 0; verdict = ST_BUSY;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register extremes before the real setting
        write_reg(CFG_STAGED_SIZE, 32'hffff_ffff);
        write_reg(CFG_MAGIC, 32'hffff_ffff);
        write_reg(CFG_VERSION, 32'h0000_ffff);
        write_reg(CFG_STAGED_SIZE, 32'd0);
        write_reg(CFG_MAGIC, 32'd0);
        write_reg(CFG_VERSION, 32'd0);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // Image layout: window edges and both sides of the protected words first
        addrs[0] = 32'h6000;  lens[0] = 2;
        addrs[1] = 32'hff7e;  lens[1] = 2;
        addrs[2] = 32'hff90;  lens[2] = 2;
        addrs[3] = 32'h15ff6; lens[3] = 2;
        cursor = 32'h6002;
        for (int i = NUM_FIXED; i < NUM_SECS; i++)
        begin
            cursor += 2 * $urandom_range(0, 32);
            addrs[i] = cursor;
            lens[i] = 2 * $urandom_range(1, 54);
            cursor += lens[i];
        end
        total = 32 + 12 * NUM_SECS;
        icrc = '1;
        for (int i = 0; i < NUM_SECS; i++)
        begin
            c = '1;
            for (int k = 0; k < lens[i]; k++)
            begin
                payload.push_back(8'($urandom));
                c = crc_step(c, payload[$]);
                icrc = crc_step(icrc, payload[$]);
            end
            crcs[i] = ~c;
            total += lens[i];
        end

        // 0: clean, 1: flipped byte, 2: stray command, 3: wrong image CRC
        mode = $urandom_range(0, 7);
        if (mode > 3)
            mode = 0;
        hit = $urandom_range(0, payload.size() - 1);

        write_reg(CFG_STAGED_SIZE, total);
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // Directed rows: header and the edge sections
        rows[0].item = rand_item(CMD_HEADER);
        rows[0].item.magic = cfg_magic;
        rows[0].item.fmt_ver = cfg_ver;
        rows[0].item.hdr_len = 16'd32;
        rows[0].item.tot_len = total;
        rows[0].item.target = TARGET_CODE_REQ;
        rows[0].item.sec_count = 16'(NUM_SECS);
        rows[0].item.img_crc = (mode == 3) ? ~icrc : icrc;
        rows[0].typed = 1;
        rows[0].status = ST_BUSY;
        for (int i = 0; i < NUM_FIXED; i++)
        begin
            rows[i + 1].item = rand_item(CMD_ENTRY);
            rows[i + 1].item.sec_addr = addrs[i];
            rows[i + 1].item.sec_len = lens[i];
            rows[i + 1].item.sec_crc = crcs[i];
            rows[i + 1].typed = (i == 0);
            rows[i + 1].status = ST_BUSY;
        end
        foreach (rows[r])
            send_item(rows[r].item, rows[r].typed, rows[r].status);

        // Remaining table entries
        for (int i = NUM_FIXED; i < NUM_SECS; i++)
        begin
            it = rand_item(CMD_ENTRY);
            it.sec_addr = addrs[i];
            it.sec_len = lens[i];
            it.sec_crc = crcs[i];
            send_item(it);
        end

        // Registers rewritten once the table is in
        drain();
        write_reg(CFG_MAGIC, $urandom);
        write_reg(CFG_VERSION, $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // Payload, with a no-idle stretch in the middle
        for (pos = 0; pos < payload.size(); pos++)
        begin
            quiet = (pos >= 200 && pos < 330);
            if (mode == 2 && pos == hit)
                send_item(rand_item(CMD_BAD));
            it = rand_item(CMD_DATA);
            it.dbyte = (mode == 1 && pos == hit) ? ~payload[pos] : payload[pos];
            send_item(it);
        end
        quiet = 0;

        // Items after the verdict, all kinds
        for (int n = 0; n < 40; n++)
            send_item(rand_item(2'($urandom_range(0, 3))));

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/fiv_pkg.sv
sv/firmware_image_validator.sv
sv/fiv_checker.sv
sim/tb_firmware_image_validator.sv
